// ===== src/rmsp_pkg.sv =====
`default_nettype none
package rmsp_pkg;

  typedef enum logic [1:0] {
    CMD_ACCUM  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LRATE = 2'd0,
    REG_DECAY = 2'd1,
    REG_EPS   = 2'd2,
    REG_BATCH = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_DIVB,
    ST_GSQ,
    ST_MS1,
    ST_MS2,
    ST_SQRT,
    ST_DIVW,
    ST_WB,
    ST_DONE
  } state_e;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned NumWeights = 256;
  localparam int unsigned DataWidth = 32;

endpackage
`default_nettype wire

// ===== src/rmsprop_weight_update_engine_top.sv =====
`default_nettype none
// channel  | handshake        | payload
// config   | cfg_we_i         | cfg_index_i, cfg_data_i
// request  | start_i, busy_o  | cmd_i, weight_index_i, downstream_gradient_i,
//          |                  | activation_i, load_value_i
// result   | done_o           | weight_value_o, mean_square_value_o,
//          |                  | gradient_sum_value_o, saturated_o
// load and no-op keep busy_o high through READ, FETCH, WB and DONE; accumulate adds
// MUL, ACC; update adds DIVB (batch division), GSQ, MS1, MS2, SQRT, DIVW (step division)
// done_o pulses in the last busy cycle; the receiver cannot stall
// reset sets the state and config registers, then sweeps all 256 entries of the mean
// square and sum stores to zero, one entry a cycle, with busy_o high
module rmsprop_weight_update_engine_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rmsp_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [rmsp_pkg::CfgWidth-1:0]      cfg_data_i,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         cmd_i,
  input  wire logic [7:0]                         weight_index_i,
  input  wire logic signed [31:0]                 downstream_gradient_i,
  input  wire logic [30:0]                        activation_i,
  input  wire logic signed [31:0]                 load_value_i,
  output logic                                    done_o,
  output logic signed [31:0]                      weight_value_o,
  output logic [31:0]                             mean_square_value_o,
  output logic signed [31:0]                      gradient_sum_value_o,
  output logic                                    saturated_o
);

  localparam int unsigned AW = (rmsp_pkg::NumWeights > 1) ? $clog2(rmsp_pkg::NumWeights) : 1;
  localparam int unsigned DW = rmsp_pkg::DataWidth;
  localparam int unsigned PW = 2 * DW + 2;
  localparam int unsigned CW = $clog2(DW + 2) + 1;
  localparam logic signed [PW-1:0] SMax = PW'((65'sd1 <<< (DW - 1)) - 65'sd1);
  localparam logic signed [PW-1:0] SMin = -SMax - PW'(1);
  localparam logic [PW-1:0] UMax = PW'((66'd1 << DW) - 66'd1);

  logic [DW-1:0] w_mem [rmsp_pkg::NumWeights];
  logic [DW-1:0] m_mem [rmsp_pkg::NumWeights];
  logic [DW-1:0] g_mem [rmsp_pkg::NumWeights];

  rmsp_pkg::state_e state_q, state_d;
  logic [15:0] lr_q, dec_q, eps_q;
  logic [10:0] bs_q;
  logic [AW:0] clr_q;
  logic clr_done;
  logic [AW-1:0] idx_q;
  logic [1:0] cmd_q;
  logic signed [31:0] dg_q, ld_q;
  logic [30:0] act_q;
  logic [DW-1:0] w_rd_q, m_rd_q, g_rd_q;
  logic signed [DW-1:0] w_q, g_q;
  logic [DW-1:0] m_q;
  logic sat_q;
  logic signed [PW-1:0] p_q;
  logic neg_q;
  logic [CW-1:0] cnt_q;
  // shared shift-subtract unit: remainder, quotient/root, numerator bits, denominator
  logic [PW-1:0] rem_q, quo_q, num_q, den_q;
  logic [DW-1:0] gabs_q;
  logic signed [DW-1:0] gavg_q;
  logic wr_en;

  assign clr_done = clr_q[AW];
  assign busy_o = (state_q != rmsp_pkg::ST_IDLE) || !clr_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= 16'd9830;
      dec_q <= 16'd58982;
      eps_q <= 16'd1;
      bs_q  <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (rmsp_pkg::reg_e'(cfg_index_i))
        rmsp_pkg::REG_LRATE: lr_q <= cfg_data_i;
        rmsp_pkg::REG_DECAY: dec_q <= cfg_data_i;
        rmsp_pkg::REG_EPS:   eps_q <= cfg_data_i;
        rmsp_pkg::REG_BATCH: bs_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmsp_pkg::ST_IDLE:  if (start_i && clr_done) state_d = rmsp_pkg::ST_READ;
      rmsp_pkg::ST_READ:  state_d = rmsp_pkg::ST_FETCH;
      rmsp_pkg::ST_FETCH: begin
        unique case (rmsp_pkg::cmd_e'(cmd_q))
          rmsp_pkg::CMD_ACCUM:  state_d = rmsp_pkg::ST_MUL;
          rmsp_pkg::CMD_UPDATE: state_d = rmsp_pkg::ST_DIVB;
          default:              state_d = rmsp_pkg::ST_WB;
        endcase
      end
      rmsp_pkg::ST_MUL:  state_d = rmsp_pkg::ST_ACC;
      rmsp_pkg::ST_ACC:  state_d = rmsp_pkg::ST_WB;
      rmsp_pkg::ST_DIVB: if (cnt_q == '0) state_d = rmsp_pkg::ST_GSQ;
      rmsp_pkg::ST_GSQ:  state_d = rmsp_pkg::ST_MS1;
      rmsp_pkg::ST_MS1:  state_d = rmsp_pkg::ST_MS2;
      rmsp_pkg::ST_MS2:  state_d = rmsp_pkg::ST_SQRT;
      rmsp_pkg::ST_SQRT: if (cnt_q == '0) state_d = rmsp_pkg::ST_DIVW;
      rmsp_pkg::ST_DIVW: if (cnt_q == '0) state_d = rmsp_pkg::ST_WB;
      rmsp_pkg::ST_WB:   state_d = rmsp_pkg::ST_DONE;
      rmsp_pkg::ST_DONE: state_d = rmsp_pkg::ST_IDLE;
      default:           state_d = rmsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == rmsp_pkg::ST_DONE);
    wr_en  = (state_q == rmsp_pkg::ST_WB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsp_pkg::ST_IDLE;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (!clr_done) begin
        clr_q <= (clr_q[AW-1:0] == AW'(rmsp_pkg::NumWeights - 1)) ? {1'b1, {AW{1'b0}}}
                                                                  : clr_q + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (!clr_done) begin
      m_mem[clr_q[AW-1:0]] <= '0;
      g_mem[clr_q[AW-1:0]] <= '0;
    end else if (wr_en) begin
      w_mem[idx_q] <= w_q;
      m_mem[idx_q] <= m_q;
      g_mem[idx_q] <= g_q;
    end
    w_rd_q <= w_mem[idx_q];
    m_rd_q <= m_mem[idx_q];
    g_rd_q <= g_mem[idx_q];
  end

  // datapath
  logic [PW-1:0] trial;
  logic [PW-1:0] rem_sh;
  logic [PW-1:0] sq_t;
  logic signed [PW-1:0] wnew_t;
  logic [PW-1:0] step_mag;
  logic [DW-1:0] gmag_rd;
  logic signed [2*DW-1:0] acc_prod;
  logic [2*DW-1:0] gsq_prod;
  logic [2*DW-1:0] lr_prod;
  always_comb begin
    rem_sh = {rem_q[PW-2:0], num_q[PW-1]};
    trial  = rem_sh - den_q;
    sq_t   = {rem_q[PW-3:0], num_q[PW-1:PW-2]} - {quo_q[PW-3:0], 2'b01};
    step_mag = neg_q ? -quo_q : quo_q;
    wnew_t = PW'($signed(w_q)) - $signed(step_mag);
    gmag_rd = g_rd_q[DW-1] ? -g_rd_q : g_rd_q;
    acc_prod = $signed(dg_q) * $signed({1'b0, act_q});
    gsq_prod = gabs_q * gabs_q;
    lr_prod = gabs_q * lr_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rmsp_pkg::ST_IDLE: begin
        idx_q <= weight_index_i[AW-1:0];
        cmd_q <= cmd_i;
        dg_q  <= downstream_gradient_i;
        act_q <= activation_i;
        ld_q  <= load_value_i;
        sat_q <= 1'b0;
      end
      rmsp_pkg::ST_FETCH: begin
        w_q <= (rmsp_pkg::cmd_e'(cmd_q) == rmsp_pkg::CMD_LOAD)
               ? DW'(ld_q) : w_rd_q;
        m_q <= m_rd_q;
        g_q <= g_rd_q;
        neg_q <= g_rd_q[DW-1];
        num_q <= {gmag_rd, {(PW-DW){1'b0}}};
        den_q <= PW'((bs_q == 11'd0) ? 11'd1 : bs_q);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CW'(DW);
      end
      rmsp_pkg::ST_MUL: p_q <= PW'(acc_prod);
      rmsp_pkg::ST_ACC: begin
        begin : acc_blk
          logic signed [PW-1:0] s;
          s = PW'($signed(g_q)) + (p_q >>> 16);
          if (s > SMax) begin
            g_q <= DW'(SMax); sat_q <= 1'b1;
          end else if (s < SMin) begin
            g_q <= DW'(SMin); sat_q <= 1'b1;
          end else begin
            g_q <= DW'(s);
          end
        end
      end
      rmsp_pkg::ST_DIVB: begin
        num_q <= num_q << 1;
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
          if (!trial[PW-1]) begin
            rem_q <= trial; quo_q <= {quo_q[PW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[PW-2:0], 1'b0};
          end
        end else begin
          gabs_q <= DW'(quo_q);
          gavg_q <= neg_q ? -DW'(quo_q) : DW'(quo_q);
        end
      end
      rmsp_pkg::ST_GSQ: p_q <= PW'(gsq_prod);
      rmsp_pkg::ST_MS1: begin
        p_q <= PW'(p_q >> 16) * PW'(17'd65536 - {1'b0, dec_q});
        quo_q <= PW'(m_q) * PW'(dec_q);
      end
      rmsp_pkg::ST_MS2: begin
        begin : ms_blk
          logic [PW-1:0] a;
          a = (p_q + quo_q) >> 16;
          if (a > UMax) begin
            m_q <= DW'(UMax); sat_q <= 1'b1;
            num_q <= UMax << (PW - DW);
          end else begin
            m_q <= DW'(a);
            num_q <= a << (PW - DW);
          end
        end
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CW'(DW / 2 + 8);
      end
      rmsp_pkg::ST_SQRT: begin
        // (m << 16) sqrt: DW/2 + 8 result bits, two radicand bits a cycle
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
          num_q <= num_q << 2;
          if (!sq_t[PW-1]) begin
            rem_q <= sq_t; quo_q <= {quo_q[PW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[PW-3:0], num_q[PW-1:PW-2]};
            quo_q <= {quo_q[PW-2:0], 1'b0};
          end
        end else begin
          den_q <= quo_q + PW'((eps_q == 16'd0) ? 16'd1 : eps_q);
          neg_q <= gavg_q[DW-1];
          // |g| * rate, aligned to the top of the dividend
          num_q <= PW'(lr_prod) << (PW - DW - 16);
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= CW'(DW + 16);
        end
      end
      rmsp_pkg::ST_DIVW: begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
          num_q <= num_q << 1;
          if (!trial[PW-1]) begin
            rem_q <= trial; quo_q <= {quo_q[PW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[PW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (state_q == rmsp_pkg::ST_DIVW && state_d == rmsp_pkg::ST_WB) begin
      if (wnew_t > SMax) begin
        w_q <= DW'(SMax); sat_q <= 1'b1;
      end else if (wnew_t < SMin) begin
        w_q <= DW'(SMin); sat_q <= 1'b1;
      end else begin
        w_q <= DW'(wnew_t);
      end
      g_q <= '0;
    end
    if (state_q == rmsp_pkg::ST_WB) begin
      weight_value_o       <= 32'(w_q);
      mean_square_value_o  <= 32'(m_q);
      gradient_sum_value_o <= 32'(g_q);
      saturated_o          <= sat_q;
    end
  end

endmodule
`default_nettype wire

// ===== dv/rmsprop_weight_update_engine_top_tb.sv =====
module rmsprop_weight_update_engine_top_tb;

  localparam int NumWeights = 256;
  localparam longint SMax = 64'sd2147483647;
  localparam longint SMin = -64'sd2147483648;
  localparam longint unsigned UMax = 64'hFFFF_FFFF;
  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 1400;
  localparam int SettleCycles = 100;

  localparam rmsp_pkg::cmd_e CmdAcc = rmsp_pkg::CMD_ACCUM;
  localparam rmsp_pkg::cmd_e CmdUpd = rmsp_pkg::CMD_UPDATE;
  localparam rmsp_pkg::cmd_e CmdLd  = rmsp_pkg::CMD_LOAD;
  localparam rmsp_pkg::cmd_e CmdNop = rmsp_pkg::CMD_NOP;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [31:0]        mean_sq;
    logic signed [31:0] grad_sum;
    logic               sat;
  } entry_report_t;

  typedef struct {
    rmsp_pkg::cmd_e     cmd;
    logic [7:0]         idx;
    logic signed [31:0] grad;
    logic [30:0]        act;
    logic signed [31:0] load;
    bit                 typed;
    entry_report_t      want;
  } request_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic start_i;
  logic busy_o;
  logic [1:0] cmd_i;
  logic [7:0] weight_index_i;
  logic signed [31:0] downstream_gradient_i;
  logic [30:0] activation_i;
  logic signed [31:0] load_value_i;
  logic done_o;
  logic signed [31:0] weight_value_o;
  logic [31:0] mean_square_value_o;
  logic signed [31:0] gradient_sum_value_o;
  logic saturated_o;

  rmsprop_weight_update_engine_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .weight_index_i(weight_index_i),
    .downstream_gradient_i(downstream_gradient_i), .activation_i(activation_i),
    .load_value_i(load_value_i),
    .done_o(done_o), .weight_value_o(weight_value_o),
    .mean_square_value_o(mean_square_value_o),
    .gradient_sum_value_o(gradient_sum_value_o), .saturated_o(saturated_o)
  );

  // shadow copy of the engine state
  longint unsigned eta_q, decay_q, eps_q, batch_q;
  longint weight_mem [NumWeights];
  longint unsigned msq_mem [NumWeights];
  longint gsum_mem [NumWeights];
  bit loaded [NumWeights];

  entry_report_t pending_reports [$];
  int errors, cycles, n_accum, n_update, n_load, n_nop, n_sat, n_results;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip_signed(longint v, ref bit sat);
    if (v > SMax) begin
      sat = 1'b1;
      return SMax;
    end
    if (v < SMin) begin
      sat = 1'b1;
      return SMin;
    end
    return v;
  endfunction

  function automatic entry_report_t rmsprop_step(rmsp_pkg::cmd_e c, int i,
                                                 logic signed [31:0] grad,
                                                 logic [30:0] act, logic signed [31:0] ld);
    entry_report_t r;
    bit sat;
    longint g, a, q, stp;
    longint unsigned bs, ep, mag, gsq, acc, msv, den;
    sat = 1'b0;
    case (c)
      rmsp_pkg::CMD_ACCUM: begin
        g = grad;
        a = longint'({33'd0, act});
        q = (g * a) >>> 16;
        gsum_mem[i] = clip_signed(gsum_mem[i] + q, sat);
      end
      rmsp_pkg::CMD_UPDATE: begin
        bs = (batch_q == 0) ? 1 : batch_q;
        ep = (eps_q == 0) ? 1 : eps_q;
        g = gsum_mem[i] / longint'(bs);
        mag = (g < 0) ? longint'(-g) : longint'(g);
        gsq = (mag * mag) >> 16;
        acc = decay_q * msq_mem[i] + (64'd65536 - decay_q) * gsq;
        msv = acc >> 16;
        if (msv > UMax) begin
          msv = UMax;
          sat = 1'b1;
        end
        msq_mem[i] = msv;
        den = int_sqrt(msv << 16) + ep;
        stp = (longint'(eta_q) * g) / longint'(den);
        weight_mem[i] = clip_signed(weight_mem[i] - stp, sat);
        gsum_mem[i] = 0;
      end
      rmsp_pkg::CMD_LOAD: begin
        weight_mem[i] = ld;
        loaded[i] = 1'b1;
      end
      default: ;
    endcase
    r.weight = weight_mem[i][31:0];
    r.mean_sq = msq_mem[i][31:0];
    r.grad_sum = gsum_mem[i][31:0];
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk_i) begin
    entry_report_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && done_o) begin
      n_results <= n_results + 1;
      if (saturated_o) n_sat <= n_sat + 1;
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        errors++;
      end else begin
        e = pending_reports.pop_front();
        if (weight_value_o !== e.weight) begin
          $display("%0t: weight exp %h got %h", $time, e.weight, weight_value_o);
          errors++;
        end
        if (mean_square_value_o !== e.mean_sq) begin
          $display("%0t: mean square exp %h got %h", $time, e.mean_sq, mean_square_value_o);
          errors++;
        end
        if (gradient_sum_value_o !== e.grad_sum) begin
          $display("%0t: grad sum exp %h got %h", $time, e.grad_sum, gradient_sum_value_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  task automatic issue(request_row_t rq, int gap);
    entry_report_t p;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= rq.cmd;
    weight_index_i <= rq.idx;
    downstream_gradient_i <= rq.grad;
    activation_i <= rq.act;
    load_value_i <= rq.load;
    do @(posedge clk_i); while (busy_o);
    p = rmsprop_step(rq.cmd, rq.idx, rq.grad, rq.act, rq.load);
    if (rq.typed) p = rq.want;
    pending_reports = {pending_reports, p};
    case (rq.cmd)
      rmsp_pkg::CMD_ACCUM:  n_accum++;
      rmsp_pkg::CMD_UPDATE: n_update++;
      rmsp_pkg::CMD_LOAD:   n_load++;
      default:              n_nop++;
    endcase
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(rmsp_pkg::reg_e r, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (r)
      rmsp_pkg::REG_LRATE: eta_q = v;
      rmsp_pkg::REG_DECAY: decay_q = v;
      rmsp_pkg::REG_EPS:   eps_q = v;
      default:             batch_q = v & 16'h07FF;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
      default: return $signed($urandom_range(4096)) - 32'sd2048;
    endcase
  endfunction

  function automatic request_row_t random_request();
    request_row_t rq;
    int k;
    k = $urandom_range(99);
    rq.cmd = (k < 55) ? CmdAcc : (k < 80) ? CmdUpd : (k < 94) ? CmdLd : CmdNop;
    rq.idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    if ($urandom_range(1)) rq.idx = ~rq.idx;
    if (!loaded[rq.idx]) rq.cmd = CmdLd;
    rq.grad = pick_value();
    rq.act = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(200000));
    rq.load = pick_value();
    rq.typed = 1'b0;
    rq.want = '0;
    return rq;
  endfunction

  request_row_t directed [$];
  logic [15:0] settings [10][4];

  initial begin
    request_row_t rq;
    int gap, quiet;
    errors = 0;
    cycles = 0;
    n_accum = 0;
    n_update = 0;
    n_load = 0;
    n_nop = 0;
    n_sat = 0;
    n_results = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = rmsp_pkg::REG_LRATE;
    cfg_data_i = '0;
    start_i = 1'b0;
    cmd_i = CmdNop;
    weight_index_i = '0;
    downstream_gradient_i = '0;
    activation_i = '0;
    load_value_i = '0;
    eta_q = 9830;
    decay_q = 58982;
    eps_q = 1;
    batch_q = 1;
    for (int i = 0; i < NumWeights; i++) begin
      weight_mem[i] = 0;
      msq_mem[i] = 0;
      gsum_mem[i] = 0;
      loaded[i] = 1'b0;
    end

    //   cmd     idx     grad           act            load           typed
    directed = '{
      '{CmdLd,  8'd0,   32'sd0,        31'd0,         32'h7FFF_FFFF, 1'b1,
        '{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0}},
      '{CmdLd,  8'd255, 32'sd0,        31'd0,         32'h8000_0000, 1'b1,
        '{32'h8000_0000, 32'd0, 32'd0, 1'b0}},
      '{CmdNop, 8'd0,   32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0,        1'b1,
        '{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0}},
      '{CmdAcc, 8'd0,   32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0,        1'b1,
        '{32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1'b1}},
      '{CmdAcc, 8'd255, 32'h8000_0000, 31'h7FFF_FFFF, 32'sd0,        1'b1,
        '{32'h8000_0000, 32'd0, 32'h8000_0000, 1'b1}},
      '{CmdAcc, 8'd0,   32'sd0,        31'h7FFF_FFFF, 32'sd0,        1'b1,
        '{32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 1'b0}},
      '{CmdUpd, 8'd0,   32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdUpd, 8'd255, 32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdUpd, 8'd0,   32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdLd,  8'd7,   32'sd0,        31'd0,         32'sd65536,    1'b1,
        '{32'sd65536, 32'd0, 32'd0, 1'b0}},
      '{CmdAcc, 8'd7,   32'sd65536,    31'd65536,     32'sd0,        1'b1,
        '{32'sd65536, 32'd0, 32'sd65536, 1'b0}},
      '{CmdAcc, 8'd7,   -32'sd1,       31'd1,         32'sd0,        1'b1,
        '{32'sd65536, 32'd0, 32'sd65535, 1'b0}},
      '{CmdUpd, 8'd7,   32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdAcc, 8'd7,   -32'sd98304,   31'd40000,     32'sd0,        1'b0, '0},
      '{CmdUpd, 8'd7,   32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdNop, 8'd7,   32'sd0,        31'd0,         32'sd0,        1'b0, '0},
      '{CmdLd,  8'd128, 32'sd0,        31'd0,         32'h5555_AAAA, 1'b1,
        '{32'h5555_AAAA, 32'd0, 32'd0, 1'b0}},
      '{CmdAcc, 8'd128, 32'h2AAA_5555, 31'h2AAA_5555, 32'sd0,        1'b0, '0},
      '{CmdUpd, 8'd128, 32'sd0,        31'd0,         32'sd0,        1'b0, '0}
    };

    // lrate, decay, eps, batch; defaults first, then extremes, zero eps and batch, and mixed values
    settings = '{
      '{16'd9830,  16'd58982, 16'd1,     16'd1},
      '{16'd65535, 16'd65535, 16'd65535, 16'd1024},
      '{16'd0,     16'd0,     16'd1,     16'd1},
      '{16'd65535, 16'd0,     16'd0,     16'd0},
      '{16'd32768, 16'd32768, 16'd256,   16'd2047},
      '{16'd1,     16'd65535, 16'd65535, 16'd4},
      '{16'hFFFF,  16'h0001,  16'hAAAA,  16'h0555},
      '{16'h5555,  16'hAAAA,  16'h5555,  16'h02AA},
      '{16'd9830,  16'd58982, 16'd1,     16'd8},
      '{16'd65535, 16'd65535, 16'd0,     16'd2}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) issue(directed[i], $urandom_range(13));

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(rmsp_pkg::REG_LRATE, settings[ph][0]);
      write_reg(rmsp_pkg::REG_DECAY, settings[ph][1]);
      write_reg(rmsp_pkg::REG_EPS, settings[ph][2]);
      write_reg(rmsp_pkg::REG_BATCH, settings[ph][3]);
      cfg_we_i <= 1'b0;
      quiet = $urandom_range(1);
      for (int n = 0; n < RandomItems / 10; n++) begin
        rq = random_request();
        gap = quiet ? 0 : $urandom_range(13);
        issue(rq, gap);
      end
    end

    drain();
    $display("requests: %0d accumulate, %0d update, %0d load, %0d no-op",
             n_accum, n_update, n_load, n_nop);
    $display("results checked: %0d, %0d with saturation, 10 register settings",
             n_results, n_sat);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
